### rtl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg: shared types and constants for the picker position to RGB block
// Word layouts, register indexes, reset values and colour sector codes.
// ----------------------------------------------------------------------------
package gpr_pkg;

    // coordinate and channel widths, fixed by the word layouts
    localparam int COORD_BITS      = 12;
    localparam int CHAN_BITS       = 8;
    localparam int FRAC_BITS_DEF   = 16;

    // configuration port
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 12;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PICKER_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PICKER_HEIGHT = 1'b1;

    localparam logic [COORD_BITS-1:0] PICKER_WIDTH_RST  = 12'd100;
    localparam logic [COORD_BITS-1:0] PICKER_HEIGHT_RST = 12'd100;

    // hue sectors, named by the colours at their ends
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    // input word: cursor position inside the picker
    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } pos_word_t;

    // output word: chosen colour
    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic                 out_of_area;
    } rgb_word_t;

endpackage

### rtl/gradient_position_to_rgb.sv
// ----------------------------------------------------------------------------
// gradient_position_to_rgb: hue/saturation picker position to RGB colour
// Pipelined HSV to RGB with value fixed at full, hue taken as the fixed-point
// ratio of pos_x to the picker width and saturation as one minus pos_y / height.
// ----------------------------------------------------------------------------
// Usage
//   pos channel: one cursor position word (pos_x, pos_y) per handshake,
//   taken when pos_valid is high and pos_stall low.
//   rgb channel: one colour word per position, in order, taken when
//   rgb_valid is high and rgb_stall low. out_of_area marks a clamped position.
//   cfg port: cfg_we writes cfg_data to register cfg_index (picker_width,
//   picker_height); write only while the pipeline is empty.
// Pipeline and throughput
//   One stage per quotient bit of the two restoring dividers (FRAC_BITS + 1),
//   then sector split, product, channel select and the output register.
//   One word per cycle in steady state while rgb_stall is low.
// Reset and stall
//   rst_n clears every stage valid bit and loads both sizes with 100.
//   A stalled output holds its word; earlier stages keep filling bubbles,
//   so pos_stall rises only once every stage holds a word.
// ----------------------------------------------------------------------------
module gradient_position_to_rgb #(
    parameter int FRAC_BITS = gpr_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // position channel
    input  logic                                pos_valid,
    output logic                                pos_stall,
    input  gpr_pkg::pos_word_t                  pos_word,
    // colour channel
    output logic                                rgb_valid,
    input  logic                                rgb_stall,
    output gpr_pkg::rgb_word_t                  rgb_word,
    // configuration
    input  logic                                cfg_we,
    input  logic [gpr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [gpr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int CB = gpr_pkg::COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int CH = gpr_pkg::CHAN_BITS;
    localparam int D  = F + 1;          // divider stages
    localparam int NS = D + 4;          // all stages
    localparam int SA = D;              // sector split
    localparam int SB = D + 1;          // products
    localparam int SC = D + 2;          // channel select
    localparam int SD = D + 3;          // output register

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CB-1:0] width_reg;
    logic [CB-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gpr_pkg::PICKER_WIDTH_RST;
            height_reg <= gpr_pkg::PICKER_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gpr_pkg::REG_PICKER_WIDTH:  width_reg  <= cfg_data[CB-1:0];
                gpr_pkg::REG_PICKER_HEIGHT: height_reg <= cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    // zero size counts as one pixel
    logic [CB-1:0] width_eff;
    logic [CB-1:0] height_eff;

    assign width_eff  = (width_reg == '0)  ? CB'(1) : width_reg;
    assign height_eff = (height_reg == '0) ? CB'(1) : height_reg;

    // clamp to the picker area and flag it
    logic [CB-1:0] x_clamp;
    logic [CB-1:0] y_clamp;
    logic          area_flag;

    assign x_clamp   = (pos_word.pos_x > width_eff)  ? width_eff  : pos_word.pos_x;
    assign y_clamp   = (pos_word.pos_y > height_eff) ? height_eff : pos_word.pos_y;
    assign area_flag = (pos_word.pos_x > width_eff) || (pos_word.pos_y > height_eff);

    // ------------------------------------------------------------------
    // stage valid bits and ready chain
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_ready;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_ctrl
            logic src_valid;

            if (k == 0)
            begin : g_head
                assign src_valid = pos_valid;
            end
            else
            begin : g_body
                assign src_valid = valid_reg[k-1];
            end

            if (k == NS - 1)
            begin : g_last
                assign stage_ready[k] = !valid_reg[k] || !rgb_stall;
            end
            else
            begin : g_inner
                assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (stage_ready[k])
                    valid_reg[k] <= src_valid;
            end
        end
    endgenerate

    assign pos_stall = !stage_ready[0];
    assign rgb_valid = valid_reg[NS-1];

    // ------------------------------------------------------------------
    // restoring dividers, one quotient bit a stage, MSB first
    // hue q = (x << F) / w, sat ratio q = (y << F) / h, both in 0..ONE
    // ------------------------------------------------------------------
    logic [CB-1:0] rx_reg   [D];
    logic [CB-1:0] ry_reg   [D];
    logic [F:0]    qx_reg   [D];
    logic [F:0]    qy_reg   [D];
    logic          fdiv_reg [D];

    generate
        for (k = 0; k < D; k++)
        begin : g_div
            logic [CB:0]   trial_x;
            logic [CB:0]   trial_y;
            logic [CB:0]   diff_x;
            logic [CB:0]   diff_y;
            logic          bit_x;
            logic          bit_y;
            logic [F:0]    qx_src;
            logic [F:0]    qy_src;
            logic          flag_src;
            logic [CB-1:0] rx_next;
            logic [CB-1:0] ry_next;

            if (k == 0)
            begin : g_first
                assign trial_x  = {1'b0, x_clamp};
                assign trial_y  = {1'b0, y_clamp};
                assign qx_src   = '0;
                assign qy_src   = '0;
                assign flag_src = area_flag;
            end
            else
            begin : g_step
                assign trial_x  = {rx_reg[k-1], 1'b0};
                assign trial_y  = {ry_reg[k-1], 1'b0};
                assign qx_src   = qx_reg[k-1];
                assign qy_src   = qy_reg[k-1];
                assign flag_src = fdiv_reg[k-1];
            end

            assign diff_x  = trial_x - {1'b0, width_eff};
            assign diff_y  = trial_y - {1'b0, height_eff};
            assign bit_x   = (trial_x >= {1'b0, width_eff});
            assign bit_y   = (trial_y >= {1'b0, height_eff});
            assign rx_next = bit_x ? diff_x[CB-1:0] : trial_x[CB-1:0];
            assign ry_next = bit_y ? diff_y[CB-1:0] : trial_y[CB-1:0];

            always_ff @(posedge clk)
            begin
                if (stage_ready[k])
                begin
                    rx_reg[k]   <= rx_next;
                    ry_reg[k]   <= ry_next;
                    qx_reg[k]   <= {qx_src[F-1:0], bit_x};
                    qy_reg[k]   <= {qy_src[F-1:0], bit_y};
                    fdiv_reg[k] <= flag_src;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // stage A: scale hue by six, split sector and fraction, saturation
    // ------------------------------------------------------------------
    logic [F+2:0]       hue_x6;
    logic [2:0]         sector_raw;
    gpr_pkg::sector_t   sector_next;
    logic [F:0]         frac_next;
    logic [F:0]         sat_next;

    gpr_pkg::sector_t   sector_a_reg;
    logic [F:0]         frac_a_reg;
    logic [F:0]         sat_a_reg;
    logic               flag_a_reg;

    assign hue_x6     = {qx_reg[D-1], 2'b00} + {1'b0, qx_reg[D-1], 1'b0};
    assign sector_raw = hue_x6[F+2:F];
    assign sat_next   = ONE - qy_reg[D-1];

    // right edge lands in sector six: end of the last sector instead
    always_comb
    begin
        if (sector_raw > gpr_pkg::SEC_MAG_RED)
        begin
            sector_next = gpr_pkg::SEC_MAG_RED;
            frac_next   = ONE;
        end
        else
        begin
            sector_next = gpr_pkg::sector_t'(sector_raw);
            frac_next   = {1'b0, hue_x6[F-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[SA])
        begin
            sector_a_reg <= sector_next;
            frac_a_reg   <= frac_next;
            sat_a_reg    <= sat_next;
            flag_a_reg   <= fdiv_reg[D-1];
        end
    end

    // ------------------------------------------------------------------
    // stage B: saturation times fraction and times its complement
    // ------------------------------------------------------------------
    logic [F:0]         frac_inv;
    logic [2*F+1:0]     prod_up;
    logic [2*F+1:0]     prod_down;

    gpr_pkg::sector_t   sector_b_reg;
    logic [F:0]         mup_b_reg;
    logic [F:0]         mdown_b_reg;
    logic [F:0]         t1_b_reg;
    logic               flag_b_reg;

    assign frac_inv  = ONE - frac_a_reg;
    assign prod_up   = sat_a_reg * frac_a_reg;
    assign prod_down = sat_a_reg * frac_inv;

    always_ff @(posedge clk)
    begin
        if (stage_ready[SB])
        begin
            sector_b_reg <= sector_a_reg;
            mup_b_reg    <= prod_up[2*F:F];
            mdown_b_reg  <= prod_down[2*F:F];
            t1_b_reg     <= ONE - sat_a_reg;
            flag_b_reg   <= flag_a_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage C: falling and rising terms, channel select by sector
    // ------------------------------------------------------------------
    logic [F:0] t2;
    logic [F:0] t3;
    logic [F:0] r_next;
    logic [F:0] g_next;
    logic [F:0] b_next;

    logic [F:0] r_c_reg;
    logic [F:0] g_c_reg;
    logic [F:0] b_c_reg;
    logic       flag_c_reg;

    assign t2 = ONE - mup_b_reg;
    assign t3 = ONE - mdown_b_reg;

    always_comb
    begin
        case (sector_b_reg)
            gpr_pkg::SEC_RED_YEL:
            begin
                r_next = ONE;      g_next = t3;       b_next = t1_b_reg;
            end
            gpr_pkg::SEC_YEL_GRN:
            begin
                r_next = t2;       g_next = ONE;      b_next = t1_b_reg;
            end
            gpr_pkg::SEC_GRN_CYN:
            begin
                r_next = t1_b_reg; g_next = ONE;      b_next = t3;
            end
            gpr_pkg::SEC_CYN_BLU:
            begin
                r_next = t1_b_reg; g_next = t2;       b_next = ONE;
            end
            gpr_pkg::SEC_BLU_MAG:
            begin
                r_next = t3;       g_next = t1_b_reg; b_next = ONE;
            end
            default:
            begin
                r_next = ONE;      g_next = t1_b_reg; b_next = t2;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[SC])
        begin
            r_c_reg    <= r_next;
            g_c_reg    <= g_next;
            b_c_reg    <= b_next;
            flag_c_reg <= flag_b_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage D: scale each channel by 255 and truncate, output register
    // ------------------------------------------------------------------
    logic [F+8:0]       r_scaled;
    logic [F+8:0]       g_scaled;
    logic [F+8:0]       b_scaled;
    gpr_pkg::rgb_word_t out_reg;

    assign r_scaled = {r_c_reg, 8'b0} - {8'b0, r_c_reg};
    assign g_scaled = {g_c_reg, 8'b0} - {8'b0, g_c_reg};
    assign b_scaled = {b_c_reg, 8'b0} - {8'b0, b_c_reg};

    always_ff @(posedge clk)
    begin
        if (stage_ready[SD])
        begin
            out_reg.red         <= r_scaled[F+CH-1:F];
            out_reg.green       <= g_scaled[F+CH-1:F];
            out_reg.blue        <= b_scaled[F+CH-1:F];
            out_reg.out_of_area <= flag_c_reg;
        end
    end

    assign rgb_word = out_reg;

endmodule

### rtl/gpr_checker.sv
// ----------------------------------------------------------------------------
// gpr_checker: port-level checks for the picker position to RGB block
// Watches the two channels only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module gpr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               pos_valid,
    input logic               pos_stall,
    input gpr_pkg::pos_word_t pos_word,
    input logic               rgb_valid,
    input logic               rgb_stall,
    input gpr_pkg::rgb_word_t rgb_word
);

    localparam logic [gpr_pkg::CHAN_BITS-1:0] CHAN_FULL = '1;

    // a stalled position word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && pos_stall |=> pos_valid && $stable(pos_word))
    else $error("position word changed under stall");

    // a stalled result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb_word))
    else $error("result word changed under stall");

    // value is full, so one channel always sits at the top
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> (rgb_word.red == CHAN_FULL) || (rgb_word.green == CHAN_FULL)
                      || (rgb_word.blue == CHAN_FULL))
    else $error("no channel at full scale");

    // input is only held back when the output word is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        (!rgb_valid || !rgb_stall) |-> !pos_stall)
    else $error("input stalled while output can drain");

endmodule

bind gradient_position_to_rgb gpr_checker u_gpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pos_valid (pos_valid),
    .pos_stall (pos_stall),
    .pos_word  (pos_word),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb_word  (rgb_word)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for gradient_position_to_rgb
// Feeds cursor position words through the pos channel under several picker
// sizes, predicts each colour word from its own fixed-point HSV calculation
// and compares every colour word, field by field, in order of arrival.
// ----------------------------------------------------------------------------
module tb;

    import gpr_pkg::*;

    localparam int              FRAC        = FRAC_BITS_DEF;
    localparam longint unsigned UNIT        = 64'd1 << FRAC;
    localparam int              DRAIN_TICKS = FRAC + 10;
    localparam int              PHASES      = 8;
    localparam int              PHASE_WORDS = 191;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      pos_valid = 1'b0;
    logic                      pos_stall;
    pos_word_t                 pos_word  = '0;
    logic                      rgb_valid;
    logic                      rgb_stall = 1'b0;
    rgb_word_t                 rgb_word;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_PICKER_WIDTH;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // bench copy of the picker size registers
    logic [COORD_BITS-1:0] picker_w = PICKER_WIDTH_RST;
    logic [COORD_BITS-1:0] picker_h = PICKER_HEIGHT_RST;

    pos_word_t pending_pos[$];
    rgb_word_t expected_rgb[$];
    rgb_word_t oldest_colour;
    int        accepted_count = 0;
    int        error_count    = 0;

    gradient_position_to_rgb i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos_valid (pos_valid),
        .pos_stall (pos_stall),
        .pos_word  (pos_word),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb_word  (rgb_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // random idling, switched off for a calm stretch of words
    function automatic bit idle_now();
        return (accepted_count < 700 || accepted_count >= 1000) &&
               ($urandom_range(99) < 12);
    endfunction

    function automatic pos_word_t position(input int x, input int y);
        pos_word_t p;
        p.pos_x = x[COORD_BITS-1:0];
        p.pos_y = y[COORD_BITS-1:0];
        return p;
    endfunction

    function automatic logic [CHAN_BITS-1:0] to_channel(input longint unsigned c);
        longint unsigned scaled;
        scaled = (c * 255) >> FRAC;
        return scaled[CHAN_BITS-1:0];
    endfunction

    // colour of one cursor position under the current picker size
    function automatic rgb_word_t colour_of(input pos_word_t p,
                                            input logic [COORD_BITS-1:0] wd,
                                            input logic [COORD_BITS-1:0] ht);
        longint unsigned w, hgt, x, y, hue, hs, frac, sat, t1, t2, t3, r, g, b;
        sector_t         sector;
        rgb_word_t       c;
        w   = (wd == '0) ? 64'd1 : 64'(wd);
        hgt = (ht == '0) ? 64'd1 : 64'(ht);
        x   = 64'(p.pos_x);
        y   = 64'(p.pos_y);
        c.out_of_area = 1'b0;
        // clamp to the picker area
        if (x > w)
        begin
            x = w;
            c.out_of_area = 1'b1;
        end
        if (y > hgt)
        begin
            y = hgt;
            c.out_of_area = 1'b1;
        end
        hue  = (x << FRAC) / w;
        hs   = hue * 6;
        frac = hs & (UNIT - 1);
        // right edge lands on sector six: end of the last sector instead
        if ((hs >> FRAC) >= 6)
        begin
            sector = SEC_MAG_RED;
            frac   = UNIT;
        end
        else
            sector = sector_t'(hs[FRAC+2:FRAC]);
        sat = UNIT - (y << FRAC) / hgt;
        t1  = UNIT - sat;
        t2  = UNIT - ((sat * frac) >> FRAC);
        t3  = UNIT - ((sat * (UNIT - frac)) >> FRAC);
        case (sector)
            SEC_RED_YEL: begin r = UNIT; g = t3;   b = t1;   end
            SEC_YEL_GRN: begin r = t2;   g = UNIT; b = t1;   end
            SEC_GRN_CYN: begin r = t1;   g = UNIT; b = t3;   end
            SEC_CYN_BLU: begin r = t1;   g = t2;   b = UNIT; end
            SEC_BLU_MAG: begin r = t3;   g = t1;   b = UNIT; end
            default:     begin r = UNIT; g = t1;   b = t2;   end
        endcase
        c.red   = to_channel(r);
        c.green = to_channel(g);
        c.blue  = to_channel(b);
        return c;
    endfunction

    // register write, only called with the pipeline empty
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_PICKER_WIDTH)
            picker_w = value;
        else
            picker_h = value;
    endtask

    task automatic wait_for_drain();
        while (pending_pos.size() != 0 || pos_valid || expected_rgb.size() != 0)
            @(posedge clk);
    endtask

    // driver: present pending words, hold them while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid <= 1'b0;
            pos_word  <= '0;
        end
        else
        begin
            if (pos_valid && !pos_stall)
            begin
                expected_rgb.push_back(colour_of(pos_word, picker_w, picker_h));
                accepted_count <= accepted_count + 1;
            end
            if (!pos_valid || !pos_stall)
            begin
                if (pending_pos.size() != 0 && !idle_now())
                begin
                    pos_valid <= 1'b1;
                    pos_word  <= pending_pos.pop_front();
                end
                else
                    pos_valid <= 1'b0;
            end
        end
    end

    // monitor: check each colour word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rgb_stall <= 1'b0;
        else
        begin
            if (rgb_valid && !rgb_stall)
            begin
                if (expected_rgb.size() == 0)
                    report_mismatch($sformatf("colour word %h with none due", rgb_word));
                else
                begin
                    oldest_colour = expected_rgb.pop_front();
                    if (rgb_word.red !== oldest_colour.red)
                        report_mismatch($sformatf("red %0d, want %0d",
                                                  rgb_word.red, oldest_colour.red));
                    if (rgb_word.green !== oldest_colour.green)
                        report_mismatch($sformatf("green %0d, want %0d",
                                                  rgb_word.green, oldest_colour.green));
                    if (rgb_word.blue !== oldest_colour.blue)
                        report_mismatch($sformatf("blue %0d, want %0d",
                                                  rgb_word.blue, oldest_colour.blue));
                    if (rgb_word.out_of_area !== oldest_colour.out_of_area)
                        report_mismatch($sformatf("out_of_area %b, want %b",
                                                  rgb_word.out_of_area,
                                                  oldest_colour.out_of_area));
                end
            end
            rgb_stall <= idle_now();
        end
    end

    // stimulus
    initial
    begin
        logic [COORD_BITS-1:0] size_w[PHASES];
        logic [COORD_BITS-1:0] size_h[PHASES];
        int                    w, h, mode, x, y;

        size_w = '{12'd1, 12'd4095, 12'd0, 12'd4095, 12'd3,    12'd640, 12'd0, 12'd100};
        size_h = '{12'd1, 12'd4095, 12'd0, 12'd7,    12'd4095, 12'd480, 12'd0, 12'd100};
        size_w[6] = COORD_BITS'($urandom_range(4095, 1));
        size_h[6] = COORD_BITS'($urandom_range(4095, 1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset size of 100 by 100
        pending_pos.push_back(position(0, 0));
        pending_pos.push_back(position(100, 0));
        pending_pos.push_back(position(100, 100));
        pending_pos.push_back(position(0, 100));
        pending_pos.push_back(position(4095, 4095));
        pending_pos.push_back(position(4095, 0));
        pending_pos.push_back(position(0, 4095));
        pending_pos.push_back(position(101, 50));
        pending_pos.push_back(position(50, 101));
        pending_pos.push_back(position(8, 0));
        pending_pos.push_back(position(25, 0));
        pending_pos.push_back(position(42, 0));
        pending_pos.push_back(position(58, 0));
        pending_pos.push_back(position(75, 0));
        pending_pos.push_back(position(92, 0));
        pending_pos.push_back(position(17, 30));
        pending_pos.push_back(position(33, 70));
        pending_pos.push_back(position(50, 20));
        pending_pos.push_back(position(67, 90));
        pending_pos.push_back(position('haaa, 'h555));
        pending_pos.push_back(position('h555, 'haaa));
        pending_pos.push_back(position(99, 99));
        pending_pos.push_back(position(1, 1));
        wait_for_drain();

        // random words under a range of picker sizes
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_register(REG_PICKER_WIDTH, size_w[ph]);
            write_register(REG_PICKER_HEIGHT, size_h[ph]);
            w = (size_w[ph] == '0) ? 1 : int'(size_w[ph]);
            h = (size_h[ph] == '0) ? 1 : int'(size_h[ph]);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                mode = $urandom_range(99);
                if (mode < 70)
                begin
                    x = $urandom_range(w, 0);
                    y = $urandom_range(h, 0);
                end
                else if (mode < 82)
                begin
                    x = $urandom_range(1) ? w : 0;
                    y = $urandom_range(1) ? h : 0;
                end
                else
                begin
                    x = $urandom_range(4095);
                    y = $urandom_range(4095);
                end
                pending_pos.push_back(position(x, y));
            end
            wait_for_drain();
        end

        repeat (DRAIN_TICKS) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/gpr_pkg.sv
rtl/gradient_position_to_rgb.sv
rtl/gpr_checker.sv
sim/tb.sv
